[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// Expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition: lbl");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[src/ucfb_pkg.sv]
// ----------------------------------------------------------------------------
// ucfb_pkg
// Shared types and constants for the command frame builder.
// ----------------------------------------------------------------------------
package ucfb_pkg;

    localparam logic [15:0] CRC_SEED = 16'h1234;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // control of the CRC unit from the sequencer
    typedef struct packed {
        logic init;   // reload seed
        logic feed;   // absorb data byte
    } crc_ctl_t;

endpackage

[src/ucfb_crc16.sv]
// ----------------------------------------------------------------------------
// ucfb_crc16
// CRC-16 accumulator, poly 0x1021, MSB first, one byte per cycle on feed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ucfb_crc16
(
    input  logic                clk,
    input  logic                rst_n,
    input  ucfb_pkg::crc_ctl_t  ctl,
    input  logic [7:0]          data_byte,
    output logic [15:0]         crc
);
    import ucfb_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.init)
            crc_next = CRC_SEED;
        else if (ctl.feed)
            crc_next = crc_byte(crc_reg, data_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= CRC_SEED;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

    `ASSERT_AT(a_crc_seed_on_init, clk, rst_n, ctl.init |=> (crc_reg == CRC_SEED))

endmodule

[src/udp_command_frame_builder.sv]
// ----------------------------------------------------------------------------
// udp_command_frame_builder
// Builds CRC-protected command datagrams, one byte per output transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, mode, packet_count): one transaction
//   is one command. mode 0 start streaming, 1 stop, 2 reset telnet; mode 3 is
//   taken and dropped with no output.
//   Output channel (out_valid / out_stall): one transaction per frame byte,
//   last_byte marks the CRC low byte; streaming carries the flag after the
//   command.
//   Frame: the first byte goes into the output register after the command
//   is registered. Start frames are 10 bytes, stop/telnet 6 bytes.
//   Throughput: a microcoded step counter emits one byte per cycle while the
//   output is not stalled; the next command is taken only after the last
//   byte of the frame is in the single output register.
//   Stall: while out_stall holds a valid byte, the output register and the
//   step counter wait; in_stall stays high while a frame is being sent.
//   Reset: sequence number 0, streaming flag clear, CRC at seed, idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module udp_command_frame_builder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [31:0] packet_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_byte,
    output logic        streaming
);
    import ucfb_pkg::*;

    // command codes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_STOP   = 2'd1;
    localparam logic [1:0] MODE_TELNET = 2'd2;

    localparam logic [7:0] CMD_START  = 8'd1;
    localparam logic [7:0] CMD_STOP   = 8'd2;
    localparam logic [7:0] CMD_TELNET = 8'd5;

    localparam logic [7:0] LEN_LONG  = 8'd10;
    localparam logic [7:0] LEN_SHORT = 8'd6;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_FIRST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CRC_HI = 4'd8;
    localparam logic [STEP_W-1:0] STEP_CRC_LO = 4'd9;

    // byte source select of the microcode
    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_LEN,
        SRC_SEQ,
        SRC_CODE,
        SRC_CNT3,
        SRC_CNT2,
        SRC_CNT1,
        SRC_CNT0,
        SRC_CRC_HI,
        SRC_CRC_LO
    } byte_src_t;

    typedef struct packed {
        byte_src_t         src;
        logic              crc_feed;
        logic              skip;      // jump to target unless start command
        logic [STEP_W-1:0] target;
        logic              last;      // end of program
    } ctl_word_t;

    // microcode ROM
    function automatic ctl_word_t prog_word(input logic [STEP_W-1:0] step);
        ctl_word_t w;
        w = '{src: SRC_CRC_LO, crc_feed: 1'b0, skip: 1'b0, target: STEP_FIRST, last: 1'b1};
        case (step)
            4'd0: w = '{SRC_ZERO,   1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd1: w = '{SRC_LEN,    1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd2: w = '{SRC_SEQ,    1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd3: w = '{SRC_CODE,   1'b1, 1'b1, STEP_CRC_HI, 1'b0};
            4'd4: w = '{SRC_CNT3,   1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd5: w = '{SRC_CNT2,   1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd6: w = '{SRC_CNT1,   1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd7: w = '{SRC_CNT0,   1'b1, 1'b0, STEP_FIRST,  1'b0};
            4'd8: w = '{SRC_CRC_HI, 1'b0, 1'b0, STEP_FIRST,  1'b0};
            4'd9: w = '{SRC_CRC_LO, 1'b0, 1'b0, STEP_FIRST,  1'b1};
            default: w = '{SRC_CRC_LO, 1'b0, 1'b0, STEP_FIRST, 1'b1};
        endcase
        return w;
    endfunction

    // registers
    logic              busy_reg,      busy_next;
    logic [STEP_W-1:0] step_reg,      step_next;
    logic [7:0]        seq_reg,       seq_next;
    logic [7:0]        seq_frame_reg, seq_frame_next;
    logic              flag_reg,      flag_next;
    logic [1:0]        mode_reg,      mode_next;
    logic [31:0]       count_reg,     count_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        byte_reg,      byte_next;
    logic              last_reg,      last_next;
    logic              strm_reg,      strm_next;

    logic       in_take;
    logic       cmd_ok;
    logic       adv;
    logic       is_start;
    ctl_word_t  ctl;
    crc_ctl_t   crc_ctl;
    logic [15:0] crc;
    logic [7:0] sel_byte;

    assign in_take  = in_valid && !busy_reg;
    assign cmd_ok   = (mode == MODE_START) || (mode == MODE_STOP) || (mode == MODE_TELNET);
    assign adv      = busy_reg && (!out_valid_reg || !out_stall);
    assign is_start = (mode_reg == MODE_START);
    assign ctl      = prog_word(step_reg);

    // byte mux
    always_comb
    begin
        case (ctl.src)
            SRC_ZERO:   sel_byte = 8'h00;
            SRC_LEN:    sel_byte = is_start ? LEN_LONG : LEN_SHORT;
            SRC_SEQ:    sel_byte = seq_frame_reg;
            SRC_CODE:
            begin
                if (mode_reg == MODE_START)
                    sel_byte = CMD_START;
                else if (mode_reg == MODE_STOP)
                    sel_byte = CMD_STOP;
                else
                    sel_byte = CMD_TELNET;
            end
            SRC_CNT3:   sel_byte = count_reg[31:24];
            SRC_CNT2:   sel_byte = count_reg[23:16];
            SRC_CNT1:   sel_byte = count_reg[15:8];
            SRC_CNT0:   sel_byte = count_reg[7:0];
            SRC_CRC_HI: sel_byte = crc[15:8];
            SRC_CRC_LO: sel_byte = crc[7:0];
            default:    sel_byte = 8'h00;
        endcase
    end

    assign crc_ctl.init = in_take && cmd_ok;
    assign crc_ctl.feed = adv && ctl.crc_feed;

    ucfb_crc16 u_crc
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (crc_ctl),
        .data_byte (sel_byte),
        .crc       (crc)
    );

    // sequencer and command state
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        seq_next       = seq_reg;
        seq_frame_next = seq_frame_reg;
        flag_next      = flag_reg;
        mode_next      = mode_reg;
        count_next     = count_reg;

        if (in_take && cmd_ok)
        begin
            busy_next      = 1'b1;
            step_next      = STEP_FIRST;
            mode_next      = mode;
            count_next     = packet_count;
            seq_frame_next = seq_reg;
            seq_next       = seq_reg + 8'd1;
            if (mode == MODE_START)
                flag_next = 1'b1;
            else if (mode == MODE_STOP)
                flag_next = 1'b0;
        end
        else if (adv)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
                step_next = STEP_FIRST;
            end
            else if (ctl.skip && !is_start)
                step_next = ctl.target;
            else
                step_next = step_reg + 4'd1;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        strm_next      = strm_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            byte_next      = sel_byte;
            last_next      = ctl.last;
            strm_next      = flag_reg;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_FIRST;
            seq_reg       <= 8'd0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            seq_reg       <= seq_next;
            flag_reg      <= flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_frame_reg <= seq_frame_next;
        mode_reg      <= mode_next;
        count_reg     <= count_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        strm_reg      <= strm_next;
    end

    assign in_stall   = busy_reg;
    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;
    assign streaming  = strm_reg;

    `ASSERT_AT(a_last_ends_frame, clk, rst_n, (adv && ctl.last) |=> !busy_reg)
    `ASSERT_NEVER(a_step_in_program, clk, rst_n, busy_reg && (step_reg > STEP_CRC_LO))
    `ASSERT_AT(a_start_sets_flag, clk, rst_n, (in_take && (mode == MODE_START)) |=> flag_reg)
    `ASSERT_AT(a_seq_advances, clk, rst_n, (in_take && cmd_ok) |=> (seq_reg == $past(seq_reg) + 8'd1))

endmodule

[verif/udp_command_frame_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_command_frame_builder_tb
// Self-checking bench for the command frame builder. A directed set covers
// every command, the unused mode and the packet-count extremes. It is followed
// by about 270 random commands, with idle and stall bursts on both channels
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module udp_command_frame_builder_tb;

    import ucfb_pkg::*;

    // command requests on the mode field
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_STOP   = 2'd1;
    localparam logic [1:0] CMD_TELNET = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // command codes and total lengths carried in the datagram
    localparam logic [7:0] CODE_START  = 8'h01;
    localparam logic [7:0] CODE_STOP   = 8'h02;
    localparam logic [7:0] CODE_TELNET = 8'h05;
    localparam logic [7:0] LEN_START   = 8'd10;
    localparam logic [7:0] LEN_SHORT   = 8'd6;

    localparam int RANDOM_CMDS    = 270;
    localparam int STALL_LIMIT    = 1000;  // cycles without any transaction
    localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       stream;
    } dgram_byte_t;

    // ------------------------------------------------------------------------
    // Frame tracker: builds the expected datagram of each accepted command
    // and checks the bytes the block sends against it, oldest first.
    // ------------------------------------------------------------------------
    class frame_tracker;
        dgram_byte_t pending_bytes[$];
        logic [7:0]  seq_no;
        logic        stream_on;
        int          failures;

        function new();
            seq_no    = 8'd0;
            stream_on = 1'b0;
            failures  = 0;
        endfunction

        // CRC-16, polynomial from the package, MSB first
        function logic [15:0] crc_absorb(logic [15:0] crc, logic [7:0] b);
            logic [15:0] c;
            c = crc ^ {b, 8'h00};
            for (int i = 0; i < 8; i++)
            begin
                c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
            end
            return c;
        endfunction

        function void push_byte(logic [7:0] b, logic lst);
            dgram_byte_t e;
            e.data   = b;
            e.last   = lst;
            e.stream = stream_on;
            pending_bytes.insert(pending_bytes.size(), e);
        endfunction

        // note an accepted command and queue the bytes of its datagram
        function void take_command(logic [1:0] m, logic [31:0] cnt);
            logic [7:0]  body[$];
            logic [15:0] crc;
            case (m)
                CMD_START:
                begin
                    stream_on = 1'b1;
                    body = '{8'h00, LEN_START, seq_no, CODE_START,
                             cnt[31:24], cnt[23:16], cnt[15:8], cnt[7:0]};
                end
                CMD_STOP:
                begin
                    stream_on = 1'b0;
                    body = '{8'h00, LEN_SHORT, seq_no, CODE_STOP};
                end
                CMD_TELNET:
                begin
                    body = '{8'h00, LEN_SHORT, seq_no, CODE_TELNET};
                end
                default:
                begin
                    return;  // unused mode: dropped, no state change
                end
            endcase
            seq_no = seq_no + 8'd1;
            crc = CRC_SEED;
            foreach (body[i])
            begin
                crc = crc_absorb(crc, body[i]);
                push_byte(body[i], 1'b0);
            end
            push_byte(crc[15:8], 1'b0);
            push_byte(crc[7:0], 1'b1);
        endfunction

        function void check_byte(logic [7:0] b, logic lst, logic st);
            dgram_byte_t e;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected byte %02h (last %0b streaming %0b)", b, lst, st);
                failures++;
                return;
            end
            e = pending_bytes.pop_front();
            if (b !== e.data)
            begin
                $error("frame_byte: expected %02h, got %02h", e.data, b);
                failures++;
            end
            if (lst !== e.last)
            begin
                $error("last_byte: expected %0b, got %0b", e.last, lst);
                failures++;
            end
            if (st !== e.stream)
            begin
                $error("streaming: expected %0b, got %0b", e.stream, st);
                failures++;
            end
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic [31:0] packet_count;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        streaming;

    frame_tracker tracker;
    bit           quiet;      // no idling on either side
    bit           hold_req;   // ask the receiver for one long hold-off
    int           idle_count;

    udp_command_frame_builder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .packet_count (packet_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .last_byte    (last_byte),
        .streaming    (streaming)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sample both channels at the rising edge. The output is checked before
    // the input is noted: a command taken at this edge cannot have produced
    // a byte yet.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_byte(frame_byte, last_byte, streaming);
            if (in_valid && !in_stall)
                tracker.take_command(mode, packet_count);
        end
    end

    // Watchdog: count cycles in which no transaction happens on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, none
    // while quiet. One assignment per falling edge at most.
    initial
    begin : receiver
        int burst_left;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req   = 1'b0;
                burst_left = 0;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else if (burst_left > 0)
            begin
                out_stall <= 1'b1;
                burst_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_stall  <= 1'b1;
                burst_left = $urandom_range(0, 3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Present one command and hold it until the block takes it.
    task automatic send_command(input logic [1:0] m, input logic [31:0] cnt);
        @(negedge clk);
        in_valid     <= 1'b1;
        mode         <= m;
        packet_count <= cnt;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic rest_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Packet counts lean towards the extremes; the rest are fully random.
    function automatic logic [31:0] pick_count();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] pick_mode();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return CMD_START;
        else if (r < 13)
            return CMD_STOP;
        else if (r < 18)
            return CMD_TELNET;
        else
            return CMD_UNUSED;
    endfunction

    initial
    begin : stimulus
        bit pressure;
        tracker      = new();
        quiet        = 1'b0;
        hold_req     = 1'b0;
        idle_count   = 0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = CMD_START;
        packet_count = 32'h0;
        out_stall    = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: each command, flag transitions from both states, the
        // unused mode, and packet counts at their extremes and bit patterns.
        send_command(CMD_TELNET, 32'h0);           // telnet with flag clear
        send_command(CMD_STOP,   32'hffff_ffff);   // stop when already stopped
        send_command(CMD_START,  32'h0);           // start with packet count zero
        send_command(CMD_TELNET, 32'hdead_beef);   // telnet with flag set
        send_command(CMD_START,  32'hffff_ffff);   // start while streaming
        send_command(CMD_UNUSED, 32'h1234_5678);   // dropped
        send_command(CMD_START,  32'h8000_0001);
        send_command(CMD_STOP,   32'h0);
        send_command(CMD_UNUSED, 32'hffff_ffff);
        send_command(CMD_START,  32'h5555_5555);
        send_command(CMD_START,  32'haaaa_aaaa);
        rest_input(3);
        send_command(CMD_START,  32'h0123_4567);
        send_command(CMD_TELNET, 32'hffff_ffff);
        send_command(CMD_STOP,   32'h8000_0000);
        send_command(CMD_START,  32'h0000_0001);

        // Random commands. Around item 100 the receiver holds off while the
        // sender keeps offering, so the block fills and stalls its input.
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            quiet    = (i >= 160 && i < 185) || (i >= RANDOM_CMDS - 40);
            pressure = (i >= 100 && i < 108);
            if (i == 100)
                hold_req = 1'b1;
            if (!quiet && !pressure && $urandom_range(0, 3) == 0)
                rest_input($urandom_range(1, 4));
            send_command(pick_mode(), pick_count());
        end
        rest_input(1);

        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.outstanding() != 0)
        begin
            $error("%0d expected bytes never arrived", tracker.outstanding());
            tracker.failures++;
        end

        if (tracker.failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
